// ----- hw/rtl/tpba_pkg.sv -----
package tpba_pkg;

	localparam int unsigned BLOCKS_PER_POOL = 5;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned SIZE_W = 24;
	localparam int unsigned CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_ADDRESS      = 2'd0,
		CFG_INPUT_BLOCK_SIZE  = 2'd1,
		CFG_OUTPUT_BLOCK_SIZE = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_NO_POOL  = 2'd1,
		STS_FULL     = 2'd2,
		STS_UNKNOWN  = 2'd3
	} status_t;

	// what the current request is doing during the scan
	typedef enum logic [1:0] {
		MODE_IN_POOL,
		MODE_OUT_POOL,
		MODE_NO_POOL,
		MODE_FREE
	} mode_t;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic done;
	} dp_stat_t;

endpackage

// ----- hw/rtl/tpba_if.sv -----
interface tpba_req_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic [tpba_pkg::SIZE_W-1:0]   request_size;
	logic [tpba_pkg::ADDR_W-1:0]   release_address;

	modport source (output valid, cmd, request_size, release_address, input ready);
	modport sink (input valid, cmd, request_size, release_address, output ready);
endinterface

interface tpba_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [tpba_pkg::ADDR_W-1:0]   granted_address;
	logic [1:0]                    status;

	modport source (output valid, granted_address, status, input ready);
	modport sink (input valid, granted_address, status, output ready);
endinterface

// ----- hw/rtl/two_pool_fixed_block_allocator.sv -----
// Two-pool fixed block allocator. Input blocks sit at base + i*input_block_size,
// output blocks follow at base + BLOCKS_PER_POOL*input_block_size + i*output_block_size.
// An allocate request takes the input pool when its size equals input_block_size,
// else the output pool when it equals output_block_size, else no pool; it grants
// the lowest free block. A free request clears the first block (input i before
// output i) whose address matches. Each request gives exactly one response. Once a
// request is accepted, the block indices are walked one per cycle by a pair of
// address adders until the first free or matching block or the last index; a size
// that matches no pool ends the walk before any step. A response waits in an output
// register; a new request is taken while it waits, and the walk finishes only once
// that register is free.
module two_pool_fixed_block_allocator #(
	parameter int unsigned BLOCKS_PER_POOL = tpba_pkg::BLOCKS_PER_POOL
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tpba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpba_pkg::ADDR_W-1:0]     cfg_wdata,
	tpba_req_if.sink                        req,
	tpba_rsp_if.source                      rsp
);

	tpba_pkg::ctl_cmd_t ctl;
	tpba_pkg::dp_stat_t stat;

	tpba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	tpba_dp #(
		.BLOCKS_PER_POOL (BLOCKS_PER_POOL)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.cmd             (req.cmd),
		.request_size    (req.request_size),
		.release_address (req.release_address),
		.ctl             (ctl),
		.stat            (stat),
		.granted_address (rsp.granted_address),
		.status          (rsp.status)
	);

	// one request in flight at a time
	a_single_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while another is in flight");

	// failed requests never report an address
	a_zero_addr_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status != tpba_pkg::STS_OK) |-> rsp.granted_address == '0)
		else $error("nonzero address on failed response");

	// a new response only comes out of a walk
	a_rsp_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(!req.ready))
		else $error("response appeared without a request being processed");

endmodule

// ----- hw/rtl/tpba_ctrl.sv -----
module tpba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  tpba_pkg::dp_stat_t  stat,
	output tpba_pkg::ctl_cmd_t  ctl
);

	tpba_pkg::state_t state_q, state_d;
	logic             rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		req_ready = 1'b0;
		case (state_q)
			tpba_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = tpba_pkg::S_SCAN;
				end
			end
			tpba_pkg::S_SCAN: begin
				if (stat.done) begin
					// result register must be free or emptying this cycle
					if (!rsp_valid_q || rsp_ready) begin
						ctl.commit = 1'b1;
						state_d    = tpba_pkg::S_IDLE;
					end
				end else begin
					ctl.step = 1'b1;
				end
			end
			default: begin
				state_d = tpba_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ----- hw/rtl/tpba_dp.sv -----
module tpba_dp #(
	parameter int unsigned BLOCKS_PER_POOL = tpba_pkg::BLOCKS_PER_POOL
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tpba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tpba_pkg::ADDR_W-1:0]       cfg_wdata,
	input  logic                              cmd,
	input  logic [tpba_pkg::SIZE_W-1:0]       request_size,
	input  logic [tpba_pkg::ADDR_W-1:0]       release_address,
	input  tpba_pkg::ctl_cmd_t                ctl,
	output tpba_pkg::dp_stat_t                stat,
	output logic [tpba_pkg::ADDR_W-1:0]       granted_address,
	output logic [1:0]                        status
);

	localparam int unsigned IDX_W = (BLOCKS_PER_POOL > 1) ? $clog2(BLOCKS_PER_POOL) : 1;
	localparam int unsigned AW = tpba_pkg::ADDR_W;
	localparam int unsigned SW = tpba_pkg::SIZE_W;

	logic [AW-1:0]               base_q;
	logic [SW-1:0]               isize_q, osize_q;
	logic [BLOCKS_PER_POOL-1:0]  in_used_q, out_used_q;

	tpba_pkg::mode_t             mode_q;
	logic [AW-1:0]               rel_q;
	logic [IDX_W-1:0]            idx_q;
	logic [AW-1:0]               in_addr_q, out_addr_q;
	logic [AW-1:0]               gaddr_q;
	tpba_pkg::status_t           status_q;

	logic                        last, hit, match_in, match_out;
	logic [AW-1:0]               hit_addr;
	tpba_pkg::status_t           fail_status;
	logic [AW-1:0]               out_base;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			isize_q <= SW'(1);
			osize_q <= SW'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				tpba_pkg::CFG_BASE_ADDRESS:      base_q  <= cfg_wdata;
				tpba_pkg::CFG_INPUT_BLOCK_SIZE:  isize_q <= cfg_wdata[SW-1:0];
				tpba_pkg::CFG_OUTPUT_BLOCK_SIZE: osize_q <= cfg_wdata[SW-1:0];
				default: ;
			endcase
		end
	end

	// output pool starts right after the last input block
	assign out_base = base_q + AW'(AW'(BLOCKS_PER_POOL) * AW'(isize_q));

	assign last      = (idx_q == IDX_W'(BLOCKS_PER_POOL - 1));
	assign match_in  = (rel_q == in_addr_q);
	assign match_out = (rel_q == out_addr_q);

	always_comb begin
		hit         = 1'b0;
		hit_addr    = '0;
		fail_status = tpba_pkg::STS_UNKNOWN;
		case (mode_q)
			tpba_pkg::MODE_IN_POOL: begin
				hit         = !in_used_q[idx_q];
				hit_addr    = in_addr_q;
				fail_status = tpba_pkg::STS_FULL;
			end
			tpba_pkg::MODE_OUT_POOL: begin
				hit         = !out_used_q[idx_q];
				hit_addr    = out_addr_q;
				fail_status = tpba_pkg::STS_FULL;
			end
			tpba_pkg::MODE_NO_POOL: begin
				fail_status = tpba_pkg::STS_NO_POOL;
			end
			tpba_pkg::MODE_FREE: begin
				hit         = match_in || match_out;
				fail_status = tpba_pkg::STS_UNKNOWN;
			end
			default: ;
		endcase
	end

	assign stat.done = hit || last || (mode_q == tpba_pkg::MODE_NO_POOL);

	// request context and scan walk: one block index per cycle
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rel_q      <= release_address;
			idx_q      <= '0;
			in_addr_q  <= base_q;
			out_addr_q <= out_base;
			if (cmd == tpba_pkg::CMD_FREE) begin
				mode_q <= tpba_pkg::MODE_FREE;
			end else if (request_size == isize_q) begin
				mode_q <= tpba_pkg::MODE_IN_POOL;
			end else if (request_size == osize_q) begin
				mode_q <= tpba_pkg::MODE_OUT_POOL;
			end else begin
				mode_q <= tpba_pkg::MODE_NO_POOL;
			end
		end else if (ctl.step) begin
			idx_q      <= idx_q + IDX_W'(1);
			in_addr_q  <= in_addr_q + AW'(isize_q);
			out_addr_q <= out_addr_q + AW'(osize_q);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			gaddr_q  <= hit ? hit_addr : '0;
			status_q <= hit ? tpba_pkg::STS_OK : fail_status;
		end
	end

	// used bits; on a free the input block at an index wins over the output one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_used_q  <= '0;
			out_used_q <= '0;
		end else if (ctl.commit && hit) begin
			case (mode_q)
				tpba_pkg::MODE_IN_POOL:  in_used_q[idx_q]  <= 1'b1;
				tpba_pkg::MODE_OUT_POOL: out_used_q[idx_q] <= 1'b1;
				tpba_pkg::MODE_FREE: begin
					if (match_in) begin
						in_used_q[idx_q] <= 1'b0;
					end else begin
						out_used_q[idx_q] <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign granted_address = gaddr_q;
	assign status          = status_q;

endmodule
